FILE: sv/crc_pkg.sv
// Package for the circle raster canvas: transaction payload types and code constants.
package crc_pkg;

    // Input item modes.
    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_FILL    = 2'd1;
    localparam logic [1:0] MODE_OUTLINE = 2'd2;
    localparam logic [1:0] MODE_READ    = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RADIUS = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // Configuration register indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BG     = 2'd2;

    localparam int COORD_W = 24;
    localparam int CHAR_W  = 8;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] radius;
        logic [CHAR_W-1:0]         paint_char;
        logic [7:0]                read_col;
        logic [7:0]                read_row;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] pixel_value;
        logic [1:0]        status;
        logic              error_seen;
    } t_out;

endpackage

FILE: sv/circle_raster_canvas.sv
// Circle raster canvas top level: canvas memory, shared squaring unit and its sequencer.
// One transaction at a time; the single squaring multiplier is shared by every
// pixel, so each pixel of the paint sweep passes through S_PMUL and S_PCMP.
// Reset: synchronous, active low; clears the sequencer, the output valid flag,
// the sticky error flag and the registers (width 1, height 1, background 32).
module circle_raster_canvas
    import crc_pkg::*;
#(
    parameter int MAX_SIDE  = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Counter width that can hold the side length itself, index width for a
    // column or row, and the address width of the whole canvas.
    localparam int CNT_W  = $clog2(MAX_SIDE + 1);
    localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    // Signed width of a centre offset: a scaled pixel position minus a centre.
    localparam int POS_W  = CNT_W + FRAC_BITS;
    localparam int DW     = ((POS_W > COORD_W) ? POS_W : COORD_W) + 2;
    localparam int PW     = 2 * DW;
    localparam logic signed [DW-1:0] ONE = DW'(1) <<< FRAC_BITS;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_SQR    = 4'd2;
    localparam logic [3:0] S_SQLO   = 4'd3;
    localparam logic [3:0] S_CAPLO  = 4'd4;
    localparam logic [3:0] S_ROW    = 4'd5;
    localparam logic [3:0] S_ROWCAP = 4'd6;
    localparam logic [3:0] S_PMUL   = 4'd7;
    localparam logic [3:0] S_PCMP   = 4'd8;
    localparam logic [3:0] S_READ   = 4'd9;
    localparam logic [3:0] S_RDCAP  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // Configuration registers.
    logic [8:0]        r_frame_width;
    logic [8:0]        r_frame_height;
    logic [CHAR_W-1:0] r_bg_char;

    // Control state.
    logic [3:0] r_state, n_state;
    logic       r_err;
    logic       r_out_valid;

    // Item and datapath registers.
    logic [1:0]              r_mode;
    logic [CHAR_W-1:0]       r_char;
    logic signed [DW-1:0]    r_cx;
    logic signed [DW-1:0]    r_rad;
    logic signed [DW-1:0]    r_lo;
    logic signed [DW-1:0]    r_dx;
    logic signed [DW-1:0]    r_dy;
    logic [PW-1:0]           r_prod;
    logic [PW-1:0]           r_r2;
    logic [PW-1:0]           r_lo2;
    logic [PW-1:0]           r_dy2;
    logic [IDX_W-1:0]        r_col;
    logic [IDX_W-1:0]        r_row;
    logic [ADDR_W-1:0]       r_base;
    logic [ADDR_W-1:0]       r_rd_addr;
    logic [CHAR_W-1:0]       r_rd_data;
    logic [CHAR_W-1:0]       r_pix;
    logic [1:0]              r_status;
    t_out                    r_out;

    // Canvas memory: one write port, one registered read port, no reset.
    logic [CHAR_W-1:0] r_canvas [0:CELLS-1];

    logic              w_in_acc;
    logic              w_cfg_wr;
    logic [CNT_W-1:0]  w_w_eff;
    logic [CNT_W-1:0]  w_h_eff;
    logic              w_last_col;
    logic              w_last_row;
    logic signed [DW-1:0] w_op;
    logic signed [PW-1:0] w_sq;
    logic [PW:0]       w_d2;
    logic              w_hit;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CHAR_W-1:0] w_wdata;
    logic              w_rd_out;
    logic              w_radius_bad;

    // ------------------------------------------------------------------
    // Configuration port. A write lands in the access phase; reads are
    // answered combinationally and pready is tied high.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 9'd1;
            r_frame_height <= 9'd1;
            r_bg_char      <= CHAR_W'(32);
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_frame_width  <= pwdata[8:0];
                REG_HEIGHT: r_frame_height <= pwdata[8:0];
                REG_BG:     r_bg_char      <= pwdata[CHAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {23'd0, r_frame_width};
            REG_HEIGHT: prdata = {23'd0, r_frame_height};
            REG_BG:     prdata = {24'd0, r_bg_char};
            default:    prdata = 32'd0;
        endcase
    end

    // Effective frame size: zero counts as one, anything above the canvas
    // side is clamped to the side.
    always_comb begin
        if (r_frame_width == 9'd0) begin
            w_w_eff = CNT_W'(1);
        end else if (32'(r_frame_width) > MAX_SIDE) begin
            w_w_eff = CNT_W'(MAX_SIDE);
        end else begin
            w_w_eff = CNT_W'(r_frame_width);
        end
        if (r_frame_height == 9'd0) begin
            w_h_eff = CNT_W'(1);
        end else if (32'(r_frame_height) > MAX_SIDE) begin
            w_h_eff = CNT_W'(MAX_SIDE);
        end else begin
            w_h_eff = CNT_W'(r_frame_height);
        end
    end

    assign w_last_col = (CNT_W'(r_col) == (w_w_eff - CNT_W'(1)));
    assign w_last_row = (CNT_W'(r_row) == (w_h_eff - CNT_W'(1)));

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_radius_bad = (i_in.radius <= 0);
    assign w_rd_out     = (32'(i_in.read_col) >= 32'(w_w_eff)) ||
                          (32'(i_in.read_row) >= 32'(w_h_eff));

    // ------------------------------------------------------------------
    // Shared squaring unit. Every square the item needs (radius, inner
    // radius, each row offset, each column offset) passes through this one
    // multiplier; its product is registered and taken up in the next state.
    // ------------------------------------------------------------------
    always_comb begin
        case (r_state)
            S_SQR:   w_op = r_rad;
            S_SQLO:  w_op = r_lo;
            S_ROW:   w_op = r_dy;
            default: w_op = r_dx;
        endcase
    end

    assign w_sq = w_op * w_op;

    // Distance test on the squared distance. The filled circle keeps
    // everything up to and including the radius; the outline keeps the ring
    // from the inner radius up to, but not including, the radius.
    assign w_d2  = {1'b0, r_prod} + {1'b0, r_dy2};
    assign w_hit = (r_mode == MODE_OUTLINE) ?
                   ((w_d2 >= {1'b0, r_lo2}) && (w_d2 < {1'b0, r_r2})) :
                   (w_d2 <= {1'b0, r_r2});

    // Canvas write port: the clear sweep writes the background, the paint
    // sweep writes the paint character wherever the distance test hits.
    assign w_waddr = r_base + ADDR_W'(r_col);
    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_PCMP) && w_hit);
    assign w_wdata = (r_state == S_CLEAR) ? r_bg_char : r_char;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_canvas[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_canvas[r_rd_addr];
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in.mode)
                        MODE_CLEAR: n_state = S_CLEAR;
                        MODE_READ:  n_state = w_rd_out ? S_DONE : S_READ;
                        default:    n_state = w_radius_bad ? S_DONE : S_SQR;
                    endcase
                end
            end
            S_CLEAR: begin
                if (w_last_col && w_last_row) begin
                    n_state = S_DONE;
                end
            end
            S_SQR:    n_state = S_SQLO;
            S_SQLO:   n_state = S_CAPLO;
            S_CAPLO:  n_state = S_ROW;
            S_ROW:    n_state = S_ROWCAP;
            S_ROWCAP: n_state = S_PMUL;
            S_PMUL:   n_state = S_PCMP;
            S_PCMP: begin
                if (!w_last_col) begin
                    n_state = S_PMUL;
                end else if (w_last_row) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_READ:   n_state = S_RDCAP;
            S_RDCAP:  n_state = S_DONE;
            S_DONE: begin
                // The result waits here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && (i_in.mode == MODE_FILL || i_in.mode == MODE_OUTLINE) &&
                w_radius_bad) begin
                r_err <= 1'b1;
            end
            if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; none of them needs a reset.
    always_ff @(posedge i_clk) begin
        r_prod <= $unsigned(w_sq);
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_mode    <= i_in.mode;
                    r_char    <= i_in.paint_char;
                    r_cx      <= DW'(i_in.center_x);
                    r_rad     <= DW'(i_in.radius);
                    r_lo      <= DW'(i_in.radius) - ONE;
                    r_dx      <= -DW'(i_in.center_x);
                    r_dy      <= -DW'(i_in.center_y);
                    r_col     <= '0;
                    r_row     <= '0;
                    r_base    <= '0;
                    r_pix     <= '0;
                    r_rd_addr <= ADDR_W'(32'(i_in.read_row) * MAX_SIDE + 32'(i_in.read_col));
                    if (i_in.mode == MODE_READ) begin
                        r_status <= w_rd_out ? ST_RANGE : ST_OK;
                    end else if (i_in.mode == MODE_CLEAR) begin
                        r_status <= ST_OK;
                    end else begin
                        r_status <= w_radius_bad ? ST_RADIUS : ST_OK;
                    end
                end
            end
            S_CLEAR: begin
                if (w_last_col) begin
                    r_col  <= '0;
                    r_row  <= r_row + IDX_W'(1);
                    r_base <= r_base + ADDR_W'(MAX_SIDE);
                end else begin
                    r_col <= r_col + IDX_W'(1);
                end
            end
            S_SQLO:   r_r2  <= r_prod;
            S_CAPLO:  r_lo2 <= (r_lo > 0) ? r_prod : '0;
            S_ROWCAP: r_dy2 <= r_prod;
            S_PCMP: begin
                if (w_last_col) begin
                    r_col  <= '0;
                    r_row  <= r_row + IDX_W'(1);
                    r_base <= r_base + ADDR_W'(MAX_SIDE);
                    r_dx   <= -r_cx;
                    r_dy   <= r_dy + ONE;
                end else begin
                    r_col <= r_col + IDX_W'(1);
                    r_dx  <= r_dx + ONE;
                end
            end
            S_RDCAP:  r_pix <= r_rd_data;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.pixel_value <= r_pix;
                    r_out.status      <= r_status;
                    r_out.error_seen  <= r_err;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_err))
        else $error("sticky radius error flag dropped");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_PCMP))
        else $error("canvas written outside a sweep");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start work");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_RANGE) |-> (r_out.pixel_value == '0))
        else $error("out-of-range read returned a nonzero pixel");

    a_sweep_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR || r_state == S_PCMP) |->
            (CNT_W'(r_col) < w_w_eff && CNT_W'(r_row) < w_h_eff))
        else $error("sweep counter left the frame");

endmodule
